// ===== hw/rtl/ypm_pkg.sv =====
// shared types, constants and coefficient rounding for the yiq palette matcher
`timescale 1ns / 1ps

package ypm_pkg;

    localparam int DEF_PALETTE_ENTRIES = 16;
    localparam int DEF_PALETTE_SETS    = 2;
    localparam int DEF_COEF_FRAC_BITS  = 14;

    localparam int COLOR_W     = 8;
    localparam int MATCH_IDX_W = 4;
    localparam int LANE_LAT    = 5;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_MATCH = 1'b1;

    // rows y, i, q; columns r, g, b; millionths
    localparam int COEF_MICRO [9] = '{
         299000,  587000,  114000,
         595716, -274453, -321263,
         211456, -522591,  311135
    };

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    // round to nearest, halves away from zero on the magnitude
    function automatic longint coef_fixed(input int k, input int frac_bits);
        longint micro;
        longint mag;
        longint fx;
        micro = longint'(COEF_MICRO[k]);
        mag   = (micro < 0) ? -micro : micro;
        fx    = (mag * (longint'(1) << frac_bits) + 64'sd500000) / 64'sd1000000;
        return (micro < 0) ? -fx : fx;
    endfunction

endpackage

// ===== hw/rtl/ypm_lane.sv =====
// one palette entry: per-set color storage and pipelined yiq squared distance
`timescale 1ns / 1ps

module ypm_lane
    import ypm_pkg::*;
#(
    parameter  int PALETTE_SETS   = DEF_PALETTE_SETS,
    parameter  int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    localparam int SET_W          = (PALETTE_SETS > 1) ? $clog2(PALETTE_SETS) : 1,
    localparam int DIST_W         = 2 * COEF_FRAC_BITS + 20
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [SET_W-1:0]  wr_set,
    input  rgb_t              wr_color,
    input  logic [SET_W-1:0]  rd_set,
    input  rgb_t              rd_color,
    output logic [DIST_W-1:0] sq_dist
);

    localparam int CW   = COEF_FRAC_BITS + 1;
    localparam int PW   = COEF_FRAC_BITS + 9;
    localparam int AXW  = COEF_FRAC_BITS + 11;
    localparam int AW   = COEF_FRAC_BITS + 9;
    localparam int SQW  = 2 * AW;
    localparam int DW_D = COLOR_W + 1;

    rgb_t pal_mem [PALETTE_SETS];

    logic [COLOR_W-1:0]      in_c  [3];
    logic [COLOR_W-1:0]      pal_c [3];
    logic signed [DW_D-1:0]  diff_reg [3];
    logic signed [PW-1:0]    prod_reg [9];
    logic signed [AXW-1:0]   axis_sum [3];
    logic signed [AXW-1:0]   axis_mag [3];
    logic [AW-1:0]           axis_reg [3];
    logic [SQW-1:0]          sq_reg [3];
    logic [DIST_W-1:0]       dist_reg;
    rgb_t                    pal_rd;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pal_mem[wr_set] <= wr_color;
        end
    end

    assign pal_rd = pal_mem[rd_set];

    always_comb
    begin
        in_c[0]  = rd_color.red;
        in_c[1]  = rd_color.green;
        in_c[2]  = rd_color.blue;
        pal_c[0] = pal_rd.red;
        pal_c[1] = pal_rd.green;
        pal_c[2] = pal_rd.blue;
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            diff_reg[c] <= $signed({1'b0, in_c[c]}) - $signed({1'b0, pal_c[c]});
        end
    end

    for (genvar k = 0; k < 9; k++)
    begin : g_prod
        localparam logic signed [CW-1:0] COEF_K = CW'(coef_fixed(k, COEF_FRAC_BITS));
        always_ff @(posedge clk)
        begin
            prod_reg[k] <= PW'(COEF_K) * PW'(diff_reg[k % 3]);
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            axis_sum[r] = AXW'(prod_reg[3*r]) + AXW'(prod_reg[3*r+1])
                        + AXW'(prod_reg[3*r+2]);
            axis_mag[r] = (axis_sum[r] < 0) ? -axis_sum[r] : axis_sum[r];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            axis_reg[r] <= AW'(axis_mag[r]);
            sq_reg[r]   <= SQW'(axis_reg[r]) * SQW'(axis_reg[r]);
        end
        dist_reg <= DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
    end

    assign sq_dist = dist_reg;

endmodule

// ===== hw/rtl/ypm_min_tree.sv =====
// registered minimum tree over lane distances, lowest index wins ties
`timescale 1ns / 1ps

module ypm_min_tree
#(
    parameter  int ENTRIES = 16,
    parameter  int DIST_W  = 48,
    localparam int IDX_W   = $clog2(ENTRIES)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  logic [DIST_W-1:0] dist_in [ENTRIES],
    output logic              valid_out,
    output logic [IDX_W-1:0]  best_idx
);

    localparam int LEVELS = IDX_W;
    localparam int P2     = 1 << LEVELS;
    localparam int NODES  = P2 - 1;

    logic [DIST_W-1:0] leaf_dist [P2];
    logic [IDX_W-1:0]  leaf_idx  [P2];
    logic [DIST_W-1:0] node_dist_reg [NODES];
    logic [IDX_W-1:0]  node_idx_reg  [NODES];
    logic              vld_reg [LEVELS];

    for (genvar i = 0; i < P2; i++)
    begin : g_leaf
        if (i < ENTRIES)
        begin : g_real
            assign leaf_dist[i] = dist_in[i];
        end
        else
        begin : g_pad
            assign leaf_dist[i] = '1;
        end
        assign leaf_idx[i] = IDX_W'(i);
    end

    for (genvar n = 0; n < NODES; n++)
    begin : g_node
        localparam int LC = 2 * n + 1;
        logic [DIST_W-1:0] l_dist;
        logic [DIST_W-1:0] r_dist;
        logic [IDX_W-1:0]  l_idx;
        logic [IDX_W-1:0]  r_idx;
        if (LC >= NODES)
        begin : g_from_leaf
            assign l_dist = leaf_dist[LC - NODES];
            assign r_dist = leaf_dist[LC + 1 - NODES];
            assign l_idx  = leaf_idx[LC - NODES];
            assign r_idx  = leaf_idx[LC + 1 - NODES];
        end
        else
        begin : g_from_node
            assign l_dist = node_dist_reg[LC];
            assign r_dist = node_dist_reg[LC + 1];
            assign l_idx  = node_idx_reg[LC];
            assign r_idx  = node_idx_reg[LC + 1];
        end
        always_ff @(posedge clk)
        begin
            if (r_dist < l_dist)
            begin
                node_dist_reg[n] <= r_dist;
                node_idx_reg[n]  <= r_idx;
            end
            else
            begin
                node_dist_reg[n] <= l_dist;
                node_idx_reg[n]  <= l_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                vld_reg[l] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= valid_in;
            for (int l = 1; l < LEVELS; l++)
            begin
                vld_reg[l] <= vld_reg[l-1];
            end
        end
    end

    assign valid_out = vld_reg[LEVELS-1];
    assign best_idx  = node_idx_reg[0];

endmodule

// ===== hw/rtl/yiq_nearest_palette_match_top.sv =====
// top level of the yiq nearest palette matcher
//
//  channel   signals                                          handshake
//  request   req_type palette_set entry_index red/green/blue  start && !busy
//  result    match_index                                      done, one cycle
//
//  a transaction can be taken every cycle; busy is high only in reset and the
//  cycle after it
//  a match result passes, after its accept edge, through the input register, five lane
//  stages and one compare stage per tree level
//  loads write the palette at the accept edge and produce no result
//  palette contents are not cleared by reset; the receiver cannot stall results
`timescale 1ns / 1ps

module yiq_nearest_palette_match_top
    import ypm_pkg::*;
#(
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
    parameter int PALETTE_SETS    = DEF_PALETTE_SETS,
    parameter int COEF_FRAC_BITS  = DEF_COEF_FRAC_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   req_type,
    input  logic                   palette_set,
    input  logic [3:0]             entry_index,
    input  logic [COLOR_W-1:0]     red_in,
    input  logic [COLOR_W-1:0]     green_in,
    input  logic [COLOR_W-1:0]     blue_in,
    output logic                   done,
    output logic [MATCH_IDX_W-1:0] match_index
);

    localparam int SET_W  = (PALETTE_SETS > 1) ? $clog2(PALETTE_SETS) : 1;
    localparam int IDX_W  = $clog2(PALETTE_ENTRIES);
    localparam int DIST_W = 2 * COEF_FRAC_BITS + 20;
    localparam int LAT    = LANE_LAT + IDX_W + 1;

    logic                   busy_reg;
    logic                   accept;
    logic                   set_ok;
    logic [SET_W:0]         set_ext;
    logic [SET_W-1:0]       eff_set;
    rgb_t                   in_color;
    logic [SET_W-1:0]       s0_set_reg;
    rgb_t                   s0_color_reg;
    logic                   vld_pipe_reg [LANE_LAT+1];
    logic [DIST_W-1:0]      lane_dist [PALETTE_ENTRIES];
    logic                   tree_valid;
    logic [IDX_W-1:0]       best_idx;
    logic [IDX_W+3:0]       best_ext;

    assign accept   = start && !busy_reg;
    assign set_ok   = 32'(palette_set) < PALETTE_SETS;
    assign set_ext  = {SET_W'(0), palette_set};
    assign eff_set  = set_ok ? set_ext[SET_W-1:0] : '0;
    assign in_color = '{red: red_in, green: green_in, blue: blue_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            for (int k = 0; k <= LANE_LAT; k++)
            begin
                vld_pipe_reg[k] <= 1'b0;
            end
        end
        else
        begin
            busy_reg        <= 1'b0;
            vld_pipe_reg[0] <= accept && (req_type == REQ_MATCH);
            for (int k = 1; k <= LANE_LAT; k++)
            begin
                vld_pipe_reg[k] <= vld_pipe_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s0_set_reg   <= eff_set;
        s0_color_reg <= in_color;
    end

    for (genvar e = 0; e < PALETTE_ENTRIES; e++)
    begin : g_lane
        logic wr_en;
        assign wr_en = accept && (req_type == REQ_LOAD) && set_ok
                    && (32'(entry_index) == e);
        ypm_lane #(
            .PALETTE_SETS   (PALETTE_SETS),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .wr_en    (wr_en),
            .wr_set   (eff_set),
            .wr_color (in_color),
            .rd_set   (s0_set_reg),
            .rd_color (s0_color_reg),
            .sq_dist  (lane_dist[e])
        );
    end

    ypm_min_tree #(
        .ENTRIES (PALETTE_ENTRIES),
        .DIST_W  (DIST_W)
    ) u_min_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (vld_pipe_reg[LANE_LAT]),
        .dist_in   (lane_dist),
        .valid_out (tree_valid),
        .best_idx  (best_idx)
    );

    assign best_ext    = {4'b0000, best_idx};
    assign busy        = busy_reg;
    assign done        = tree_valid;
    assign match_index = best_ext[MATCH_IDX_W-1:0];

`ifndef SYNTHESIS
    a_match_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_MATCH) |-> ##LAT done)
        else $error("match transaction produced no result");

    a_load_gives_none: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_LOAD) |-> ##LAT !done)
        else $error("load transaction produced a result");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!(start && !busy && req_type == REQ_MATCH)) |-> ##LAT !done)
        else $error("result without a match transaction");

    a_busy_stays_low: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose after reset");
`endif

endmodule
